// ----- src/imgconv_pkg.sv -----
`default_nettype none

package imgconv_pkg;

    localparam int IMAGE_MAX    = 64;
    localparam int KERNEL_MAX   = 7;
    localparam int SAMPLE_WIDTH = 16;

    localparam int FUNC_W  = 2;
    localparam int RES_W   = 37;
    localparam int PROD_W  = 2 * SAMPLE_WIDTH;
    localparam int IDX_W   = (IMAGE_MAX > 1) ? $clog2(IMAGE_MAX) : 1;
    localparam int NSZ_W   = $clog2(IMAGE_MAX + 1);
    localparam int KIDX_W  = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX) : 1;
    localparam int KSZ_W   = $clog2(KERNEL_MAX + 1);
    localparam int CRD_W   = NSZ_W + KSZ_W + 1;
    localparam int IMG_AW  = 2 * IDX_W;
    localparam int KER_AW  = 2 * KIDX_W;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = (NSZ_W > KSZ_W) ? NSZ_W : KSZ_W;

    localparam logic [FUNC_W-1:0] FUNC_KERNEL  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PIXEL   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd2;

    localparam logic [CFG_IW-1:0] REG_IMAGE_SIZE  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_KERNEL_SIZE = 2'd1;

    localparam logic [NSZ_W-1:0] IMAGE_SIZE_RESET  = NSZ_W'(64);
    localparam logic [KSZ_W-1:0] KERNEL_SIZE_RESET = KSZ_W'(3);

    function automatic logic [NSZ_W-1:0] clamp_image(input logic [NSZ_W-1:0] v);
        logic [NSZ_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = NSZ_W'(1);
        end else if (v > NSZ_W'(IMAGE_MAX)) begin
            r = NSZ_W'(IMAGE_MAX);
        end
        return r;
    endfunction

    function automatic logic [KSZ_W-1:0] clamp_kernel(input logic [KSZ_W-1:0] v);
        logic [KSZ_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = KSZ_W'(1);
        end else if (v > KSZ_W'(KERNEL_MAX)) begin
            r = KSZ_W'(KERNEL_MAX);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/imgconv_if.sv -----
`default_nettype none

interface imgconv_in_if import imgconv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [SAMPLE_WIDTH-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface imgconv_out_if import imgconv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] result_value;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic             last_pixel;

    modport source (output valid, output result_value, output out_row, output out_col,
                    output last_pixel, input ready);
    modport sink   (input valid, input result_value, input out_row, input out_col,
                    input last_pixel, output ready);
endinterface

interface imgconv_cfg_if import imgconv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/imgconv_ram.sv -----
`default_nettype none

module imgconv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/image_convolution_2d_core.sv -----
// Channel   Direction  Contents
// i_in      sink       func, value (kernel coefficient, pixel or output request)
// o_out     source     result_value, out_row, out_col, last_pixel
// i_cfg     sink       index, data (image_size, kernel_size)
//
// A granted output request issues kernel_size squared multiply-accumulates, one per
// cycle, paced by the single read port of the image and kernel memories.
// Reset is synchronous and active low; the memories are not cleared.
// A finished result waits in the output register while the next request is taken.
`default_nettype none

module image_convolution_2d_core import imgconv_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    imgconv_in_if.sink  i_in,
    imgconv_out_if.source o_out,
    imgconv_cfg_if.sink i_cfg
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT} t_state;

    t_state r_state;

    logic [NSZ_W-1:0]  r_n;
    logic [KSZ_W-1:0]  r_k;
    logic [KIDX_W-1:0] r_kla, r_klb;
    logic              r_kdone;
    logic [IDX_W-1:0]  r_ilr, r_ilc;
    logic              r_idone;
    logic [IDX_W-1:0]  r_orow, r_ocol;
    logic [KIDX_W-1:0] r_m, r_q;
    logic              r_s1_act, r_s1_ok, r_s1_last;
    logic              r_s2_act, r_s2_last;
    logic [PROD_W-1:0] r_prod;
    logic [RES_W-1:0]  r_acc;
    logic              r_fin;
    logic              r_ovalid;
    logic [RES_W-1:0]  r_ores;
    logic [IDX_W-1:0]  r_orow_q, r_ocol_q;
    logic              r_olast;

    logic                    in_acc, cfg_acc, req_go, issue_last, in_range, out_load;
    logic [IDX_W-1:0]        n_m1;
    logic [KIDX_W-1:0]       k_m1;
    logic [KSZ_W-1:0]        half;
    logic signed [CRD_W-1:0] row_s, col_s, n_s;
    logic                    img_we, ker_we;
    logic [IMG_AW-1:0]       img_waddr, img_raddr;
    logic [KER_AW-1:0]       ker_waddr, ker_raddr;
    logic [SAMPLE_WIDTH-1:0] img_q, ker_q;
    logic                    last_px;
    logic [RES_W-1:0]        n_acc;

    assign i_in.ready  = (r_state == S_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = (r_state == S_IDLE);
    assign in_acc  = i_in.valid && i_in.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign req_go  = in_acc && (i_in.func == FUNC_REQUEST) && r_kdone && r_idone;

    assign n_m1 = IDX_W'(r_n - NSZ_W'(1));
    assign k_m1 = KIDX_W'(r_k - KSZ_W'(1));
    assign half = r_k >> 1;

    assign row_s = $signed(CRD_W'(r_orow)) + $signed(CRD_W'(r_m)) - $signed(CRD_W'(half));
    assign col_s = $signed(CRD_W'(r_ocol)) + $signed(CRD_W'(r_q)) - $signed(CRD_W'(half));
    assign n_s   = $signed(CRD_W'(r_n));
    assign in_range = (row_s >= 0) && (row_s < n_s) && (col_s >= 0) && (col_s < n_s);
    assign issue_last = (r_m == k_m1) && (r_q == k_m1);

    assign img_we    = in_acc && (i_in.func == FUNC_PIXEL) && !r_idone;
    assign img_waddr = {r_ilr, r_ilc};
    assign img_raddr = {row_s[IDX_W-1:0], col_s[IDX_W-1:0]};
    assign ker_we    = in_acc && (i_in.func == FUNC_KERNEL) && !r_kdone;
    assign ker_waddr = {KIDX_W'(k_m1 - r_kla), KIDX_W'(k_m1 - r_klb)};
    assign ker_raddr = {r_m, r_q};

    assign last_px  = (r_orow == n_m1) && (r_ocol == n_m1);
    assign out_load = (r_state == S_WAIT) && r_fin && (!r_ovalid || o_out.ready);
    assign n_acc    = r_acc + {{(RES_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    imgconv_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(2 ** IMG_AW)) u_img_ram (
        .i_clk   (i_clk),
        .i_we    (img_we),
        .i_waddr (img_waddr),
        .i_wdata (i_in.value),
        .i_raddr (img_raddr),
        .o_rdata (img_q)
    );

    imgconv_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(2 ** KER_AW)) u_ker_ram (
        .i_clk   (i_clk),
        .i_we    (ker_we),
        .i_waddr (ker_waddr),
        .i_wdata (i_in.value),
        .i_raddr (ker_raddr),
        .o_rdata (ker_q)
    );

    assign o_out.valid        = r_ovalid;
    assign o_out.result_value = r_ores;
    assign o_out.out_row      = r_orow_q;
    assign o_out.out_col      = r_ocol_q;
    assign o_out.last_pixel   = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_n       <= IMAGE_SIZE_RESET;
            r_k       <= KERNEL_SIZE_RESET;
            r_kla     <= '0;
            r_klb     <= '0;
            r_kdone   <= 1'b0;
            r_ilr     <= '0;
            r_ilc     <= '0;
            r_idone   <= 1'b0;
            r_orow    <= '0;
            r_ocol    <= '0;
            r_m       <= '0;
            r_q       <= '0;
            r_s1_act  <= 1'b0;
            r_s1_ok   <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_act  <= 1'b0;
            r_s2_last <= 1'b0;
            r_fin     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_s1_act  <= (r_state == S_RUN);
            r_s1_ok   <= (r_state == S_RUN) && in_range;
            r_s1_last <= (r_state == S_RUN) && issue_last;
            r_s2_act  <= r_s1_act;
            r_s2_last <= r_s1_last;
            r_prod    <= r_s1_ok ? PROD_W'($signed(img_q) * $signed(ker_q)) : '0;

            if (r_s2_act) begin
                r_acc <= n_acc;
                if (r_s2_last) begin
                    r_fin <= 1'b1;
                end
            end

            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            if (cfg_acc && (i_cfg.index == REG_IMAGE_SIZE || i_cfg.index == REG_KERNEL_SIZE)) begin
                if (i_cfg.index == REG_IMAGE_SIZE) begin
                    r_n <= clamp_image(NSZ_W'(i_cfg.data));
                end else begin
                    r_k <= clamp_kernel(KSZ_W'(i_cfg.data));
                end
                r_kla   <= '0;
                r_klb   <= '0;
                r_kdone <= 1'b0;
                r_ilr   <= '0;
                r_ilc   <= '0;
                r_idone <= 1'b0;
                r_orow  <= '0;
                r_ocol  <= '0;
            end

            if (ker_we) begin
                if (r_klb == k_m1) begin
                    r_klb <= '0;
                    if (r_kla == k_m1) begin
                        r_kdone <= 1'b1;
                    end else begin
                        r_kla <= r_kla + KIDX_W'(1);
                    end
                end else begin
                    r_klb <= r_klb + KIDX_W'(1);
                end
            end

            if (img_we) begin
                if (r_ilc == n_m1) begin
                    r_ilc <= '0;
                    if (r_ilr == n_m1) begin
                        r_idone <= 1'b1;
                    end else begin
                        r_ilr <= r_ilr + IDX_W'(1);
                    end
                end else begin
                    r_ilc <= r_ilc + IDX_W'(1);
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (req_go) begin
                        r_state <= S_RUN;
                        r_m     <= '0;
                        r_q     <= '0;
                        r_acc   <= '0;
                        r_fin   <= 1'b0;
                    end
                end
                S_RUN: begin
                    if (issue_last) begin
                        r_state <= S_WAIT;
                    end else if (r_q == k_m1) begin
                        r_q <= '0;
                        r_m <= r_m + KIDX_W'(1);
                    end else begin
                        r_q <= r_q + KIDX_W'(1);
                    end
                end
                S_WAIT: begin
                    if (out_load) begin
                        r_state  <= S_IDLE;
                        r_fin    <= 1'b0;
                        r_ovalid <= 1'b1;
                        r_ores   <= r_acc;
                        r_orow_q <= r_orow;
                        r_ocol_q <= r_ocol;
                        r_olast  <= last_px;
                        if (last_px) begin
                            r_kla   <= '0;
                            r_klb   <= '0;
                            r_kdone <= 1'b0;
                            r_ilr   <= '0;
                            r_ilc   <= '0;
                            r_idone <= 1'b0;
                            r_orow  <= '0;
                            r_ocol  <= '0;
                        end else if (r_ocol == n_m1) begin
                            r_ocol <= '0;
                            r_orow <= r_orow + IDX_W'(1);
                        end else begin
                            r_ocol <= r_ocol + IDX_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_no_write_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (img_we || ker_we) |-> (r_state == S_IDLE))
        else $error("memory written while a request is in progress");

    a_run_needs_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_kdone && r_idone))
        else $error("window walk started before both loads were complete");

    a_drain_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_last |-> (r_state == S_WAIT) && !r_fin)
        else $error("final accumulation outside the wait state");

    a_result_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_ovalid && (r_state == S_IDLE))
        else $error("finished request not presented on the output");
`endif

endmodule

`default_nettype wire
